>>> sv/srm_pkg.sv
// Shared types and constants for the secret redaction matcher.
// Depends on nothing; imported by the top level.
package srm_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int SYM_W = 8;
	localparam logic [SYM_W-1:0] MASK_CHAR = 8'h2A;
	localparam int MASK_COUNT = 3;

	typedef enum logic [1:0] {
		MODE_LOAD_TRANS = 2'd0,
		MODE_LOAD_LEN   = 2'd1,
		MODE_DATA       = 2'd2,
		MODE_END        = 2'd3
	} mode_t;

	// what a data or end word does once it reaches the decision stage
	typedef enum logic [1:0] {
		KIND_HOLD = 2'd0,
		KIND_PASS = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// what follows the held bytes of an emit job
	typedef enum logic [1:0] {
		TAIL_NONE  = 2'd0,
		TAIL_STARS = 2'd1,
		TAIL_BYTE  = 2'd2
	} tail_t;

	typedef struct packed {
		mode_t            mode;
		logic [7:0]       state_index;
		logic [SYM_W-1:0] symbol;
		logic [7:0]       next_state;
		logic [5:0]       match_length;
	} in_word_t;

	typedef struct packed {
		logic [SYM_W-1:0] out_byte;
		logic             last_of_run;
		logic             end_of_stream;
	} out_word_t;

endpackage

>>> sv/srm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module srm_ram #(
	parameter int W = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/secret_redaction_matcher.sv
// Top level of the secret redaction matcher: automaton lookup pipeline, holding window
// and emit sequencer. Depends on srm_pkg and srm_ram.
//
// Byte-stream redactor driven by a software-loaded Aho-Corasick automaton. Load words
// (mode 0 transition, mode 1 match length) are written into the transition RAM
// (NUM_STATES*256 entries) or the match-length RAM (NUM_STATES entries) in the cycle
// they are taken; out-of-range loads are dropped, lengths saturate at MAX_PATTERN.
// Neither RAM is cleared: reading a never-loaded entry gives garbage, and there is no
// clearing pass after reset. Data and end words pass the lookup stages s1 and s2: an
// enabled data word reads the transition RAM as it is taken and the match-length RAM
// as it leaves s1; the next data word's lookup address is forwarded from the decision,
// so a new data or end word is taken only once the previous one leaves that stage.
// Results leave one word per cycle from an output register while result_ready is high
// (a word can release up to MAX_PATTERN+2 of them), and the lookup of the next word
// overlaps that output. The holding window is a RAM of 2*MAX_PATTERN bytes used as a
// ring, so held bytes still waiting to be sent never get overwritten by newly held
// ones. redaction_enable (cfg_we/cfg_wdata) may only change while the block is idle;
// with it low, each data byte flushes the held bytes and then passes through.
module secret_redaction_matcher
	import srm_pkg::*;
#(
	parameter int NUM_STATES = 256,
	parameter int MAX_PATTERN = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	localparam int SW = $clog2(NUM_STATES);           // state number width
	localparam int TDEPTH = NUM_STATES * ALPHABET_SIZE;
	localparam int TAW = SW + SYM_W;                   // transition address width
	localparam int LW = $clog2(MAX_PATTERN + 1);       // length / count width
	localparam int MW = (LW > 6) ? LW : 6;             // width for saturation compare
	localparam int WDEPTH = 2 * MAX_PATTERN;           // window ring depth
	localparam int PW = $clog2(WDEPTH);

	// ---------------------------------------------------------------- config
	logic redact_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			redact_en_q <= 1'b0;
		end else if (cfg_we) begin
			redact_en_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------- accept
	logic item_acc;
	logic is_load;
	logic hold_acc;      // enabled data byte: look up and hold
	logic trans_ok;
	logic len_ok;
	logic s2_go;

	logic          valid_s1, valid_s2;
	kind_t         kind_s1, kind_s2;
	logic [SYM_W-1:0] sym_s1, sym_s2;
	logic [SW-1:0] ns_s2;

	logic [SW-1:0] st_q, st_nx, st_fwd;
	logic [LW-1:0] count_q, count_nx;
	logic [PW-1:0] head_q, head_nx, tail_q;

	// Only one data/end word sits in the lookup path at a time; it must be
	// leaving the decision stage for the next one to come in.
	assign item_ready = !valid_s1 && (!valid_s2 || s2_go);
	assign item_acc = item_valid && item_ready;
	assign is_load = (item.mode == MODE_LOAD_TRANS) || (item.mode == MODE_LOAD_LEN);
	assign hold_acc = item_acc && (item.mode == MODE_DATA) && redact_en_q;
	assign trans_ok = (int'(item.state_index) < NUM_STATES)
		&& (int'(item.next_state) < NUM_STATES);
	assign len_ok = int'(item.state_index) < NUM_STATES;

	// lookup uses the state the decision stage is writing this very cycle
	assign st_fwd = s2_go ? st_nx : st_q;

	// ---------------------------------------------------------------- memories
	logic [SW-1:0] t_rdata;
	logic [LW-1:0] l_rdata;
	logic [LW-1:0] len_sat;
	logic [SYM_W-1:0] win_rdata;
	logic win_re;
	logic [PW-1:0] jb_ptr_q;

	assign len_sat = (MW'(item.match_length) > MW'(MAX_PATTERN)) ?
		LW'(MAX_PATTERN) : LW'(item.match_length);

	srm_ram #(.W(SW), .DEPTH(TDEPTH)) u_trans (
		.clk   (clk),
		.we    (item_acc && (item.mode == MODE_LOAD_TRANS) && trans_ok),
		.waddr (TAW'({SW'(item.state_index), item.symbol})),
		.wdata (SW'(item.next_state)),
		.re    (hold_acc),
		.raddr (TAW'({st_fwd, item.symbol})),
		.rdata (t_rdata)
	);

	srm_ram #(.W(LW), .DEPTH(NUM_STATES)) u_len (
		.clk   (clk),
		.we    (item_acc && (item.mode == MODE_LOAD_LEN) && len_ok),
		.waddr (SW'(item.state_index)),
		.wdata (len_sat),
		.re    (valid_s1 && (kind_s1 == KIND_HOLD)),
		.raddr (t_rdata),
		.rdata (l_rdata)
	);

	// held bytes are written at the ring tail as the word is taken
	srm_ram #(.W(SYM_W), .DEPTH(WDEPTH)) u_win (
		.clk   (clk),
		.we    (hold_acc),
		.waddr (tail_q),
		.wdata (item.symbol),
		.re    (win_re),
		.raddr (jb_ptr_q),
		.rdata (win_rdata)
	);

	// ---------------------------------------------------------------- lookup stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			tail_q   <= '0;
		end else begin
			valid_s1 <= item_acc && !is_load;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (hold_acc) begin
				tail_q <= (tail_q == PW'(WDEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			sym_s1 <= item.symbol;
			if (item.mode == MODE_END) begin
				kind_s1 <= KIND_END;
			end else if (redact_en_q) begin
				kind_s1 <= KIND_HOLD;
			end else begin
				kind_s1 <= KIND_PASS;
			end
		end
		if (valid_s1) begin
			kind_s2 <= kind_s1;
			sym_s2  <= sym_s1;
			ns_s2   <= t_rdata;
		end
	end

	// ---------------------------------------------------------------- decision
	logic [LW-1:0]    c1;
	logic [LW-1:0]    new_left;
	tail_t            new_tail;
	logic             new_eos;
	logic             job_empty;
	logic             jb_free;
	logic             jb_load;

	assign c1 = count_q + 1'b1;

	always_comb begin
		st_nx    = '0;
		count_nx = count_q;
		head_nx  = head_q;
		new_left = '0;
		new_tail = TAIL_NONE;
		new_eos  = 1'b0;
		case (kind_s2)
			KIND_HOLD: begin
				if (l_rdata != '0) begin
					// match: back to root; redact only if enough is held
					if (c1 >= l_rdata) begin
						new_left = c1 - l_rdata;
						new_tail = TAIL_STARS;
						head_nx  = tail_q;
						count_nx = '0;
					end else begin
						count_nx = c1;
					end
				end else begin
					st_nx = ns_s2;
					if (c1 == LW'(MAX_PATTERN)) begin
						// window full: release the oldest byte
						new_left = LW'(1);
						head_nx  = (head_q == PW'(WDEPTH - 1)) ? '0 : head_q + 1'b1;
						count_nx = LW'(MAX_PATTERN - 1);
					end else begin
						count_nx = c1;
					end
				end
			end
			KIND_PASS: begin
				new_left = count_q;
				new_tail = TAIL_BYTE;
				head_nx  = tail_q;
				count_nx = '0;
			end
			KIND_END: begin
				new_left = count_q;
				new_eos  = 1'b1;
				head_nx  = tail_q;
				count_nx = '0;
			end
			default: begin
				st_nx = st_q;
			end
		endcase
	end

	assign job_empty = (new_left == '0) && (new_tail == TAIL_NONE);
	assign s2_go = valid_s2 && (jb_free || job_empty);
	assign jb_load = s2_go && !job_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			count_q <= '0;
			head_q  <= '0;
		end else if (s2_go) begin
			st_q    <= st_nx;
			count_q <= count_nx;
			head_q  <= head_nx;
		end
	end

	// ---------------------------------------------------------------- emit sequencer
	// One job: a run of held bytes read from the ring, then the stars, the pass-through
	// byte or nothing. One result word is issued per cycle unless result_ready stalls it.
	logic             jb_busy_q;
	logic [LW-1:0]    jb_left_q;
	tail_t            jb_tail_q;
	logic [1:0]       jb_star_q;
	logic [SYM_W-1:0] jb_byte_q;
	logic             jb_eos_q;

	logic em_issue, em_final, em_adv;
	logic             em_valid_s3, em_ram_s3, em_last_s3, em_eos_s3;
	logic [SYM_W-1:0] em_byte_s3;
	logic             out_valid_s4;
	out_word_t        out_word_s4;

	assign em_adv = em_valid_s3 && (!out_valid_s4 || result_ready);
	assign em_issue = jb_busy_q && (!em_valid_s3 || em_adv);
	assign win_re = em_issue && (jb_left_q != '0);
	assign em_final = ((jb_left_q == LW'(1)) && (jb_tail_q == TAIL_NONE))
		|| ((jb_left_q == '0) && ((jb_tail_q == TAIL_BYTE)
		|| ((jb_tail_q == TAIL_STARS) && (jb_star_q == 2'(MASK_COUNT - 1)))));
	assign jb_free = !jb_busy_q || (em_issue && em_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jb_busy_q <= 1'b0;
		end else if (jb_load) begin
			jb_busy_q <= 1'b1;
		end else if (em_issue && em_final) begin
			jb_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (jb_load) begin
			jb_left_q <= new_left;
			jb_ptr_q  <= head_q;
			jb_tail_q <= new_tail;
			jb_star_q <= '0;
			jb_byte_q <= sym_s2;
			jb_eos_q  <= new_eos;
		end else if (em_issue) begin
			if (jb_left_q != '0) begin
				jb_left_q <= jb_left_q - 1'b1;
				jb_ptr_q  <= (jb_ptr_q == PW'(WDEPTH - 1)) ? '0 : jb_ptr_q + 1'b1;
			end else if (jb_tail_q == TAIL_STARS) begin
				jb_star_q <= jb_star_q + 1'b1;
			end
		end
	end

	// s3: ring read in flight (read data holds while this stage waits)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_s3  <= 1'b0;
			out_valid_s4 <= 1'b0;
		end else begin
			if (em_issue) begin
				em_valid_s3 <= 1'b1;
			end else if (em_adv) begin
				em_valid_s3 <= 1'b0;
			end
			if (!out_valid_s4 || result_ready) begin
				out_valid_s4 <= em_valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (em_issue) begin
			em_ram_s3  <= jb_left_q != '0;
			em_byte_s3 <= (jb_tail_q == TAIL_STARS) ? MASK_CHAR : jb_byte_q;
			em_last_s3 <= em_final;
			em_eos_s3  <= em_final && jb_eos_q;
		end
		if (em_adv) begin
			out_word_s4.out_byte      <= em_ram_s3 ? win_rdata : em_byte_s3;
			out_word_s4.last_of_run   <= em_last_s3;
			out_word_s4.end_of_stream <= em_eos_s3;
		end
	end

	assign result_valid = out_valid_s4;
	assign result = out_word_s4;

`ifndef SYNTHESIS
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("lookup word lost between stages");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go |=> (count_q < LW'(MAX_PATTERN)))
		else $error("held count reached window size after a decision");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.end_of_stream) |-> result.last_of_run)
		else $error("end of stream without last of run");

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		jb_load |=> (jb_busy_q && ((jb_left_q != '0) || (jb_tail_q != TAIL_NONE))))
		else $error("empty emit job loaded");
`endif

endmodule
